### design/qmix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qmix_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 16;   // signed Q8.8 percent
  localparam int unsigned VOLT_W  = 15;   // unsigned Q7.8 volts
  localparam int unsigned DRV_W   = 16;   // signed Q8.8 volts, saturated
  localparam int unsigned MOTORS  = 4;

  // Internal widths
  localparam int unsigned MIX_W   = 18;   // sum of four commands
  localparam int unsigned PROD_W  = 34;   // mix * max_volts
  localparam int unsigned MAG_W   = 32;   // |mix * max_volts|
  localparam int unsigned SHR_W   = 22;   // magnitude >> 10
  localparam int unsigned QUO_W   = 18;   // magnitude / 25600
  localparam int unsigned SQ_W    = 19;   // signed quotient
  localparam int unsigned DS_W    = 22;   // desaturation arithmetic

  // Division by 25600 = 1024 * 25: shift by 10, then multiply by
  // ceil(2^27 / 25) and take bits [44:27]; exact for 22-bit operands.
  localparam int unsigned PRE_SHIFT = 10;
  localparam int unsigned RECIP_W   = 23;
  localparam int unsigned RECIP_SH  = 27;
  localparam logic [RECIP_W-1:0] RECIP_25 = 23'd5368710;

  // Register reset values
  localparam logic [VOLT_W-1:0] MAX_VOLTS_RST = 15'd2304;
  localparam logic [VOLT_W-1:0] MIN_VOLTS_RST = 15'd0;

  // Saturation limits
  localparam logic signed [DS_W-1:0] DRV_MAX = 22'sd32767;
  localparam logic signed [DS_W-1:0] DRV_MIN = -22'sd32768;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_VOLTS = 1'b0,
    REG_MIN_VOLTS = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

### design/qmix_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one item carries the four attitude/thrust commands
interface qmix_in_if;
  import qmix_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CMD_W-1:0]  roll_cmd;
  logic signed [CMD_W-1:0]  pitch_cmd;
  logic signed [CMD_W-1:0]  yaw_cmd;
  logic signed [CMD_W-1:0]  thrust_cmd;

  modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd, input ready);
  modport sink   (input valid, roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd, output ready);
endinterface

// Drive channel: one item carries four motor drives and the take-off flag
interface qmix_out_if;
  import qmix_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DRV_W-1:0]  motor_front_left;
  logic signed [DRV_W-1:0]  motor_front_right;
  logic signed [DRV_W-1:0]  motor_rear_right;
  logic signed [DRV_W-1:0]  motor_rear_left;
  logic                     airborne;

  modport source (output valid, motor_front_left, motor_front_right, motor_rear_right,
                  motor_rear_left, airborne, input ready);
  modport sink   (input valid, motor_front_left, motor_front_right, motor_rear_right,
                  motor_rear_left, airborne, output ready);
endinterface

`default_nettype wire

### design/quad_motor_mixer_with_desaturation_unit.sv
// X-frame quad motor mixer with desaturation.
// in_if (sink): roll, pitch, yaw and thrust commands, signed Q8.8 percent.
// out_if (source): four motor drives, signed Q8.8 volts, plus the sticky
//   take-off flag as it stands after the item.
// cfg_we/cfg_idx/cfg_data: write max_volts (index 0) or min_volts (index 1);
//   write only while no item is in flight.
// Pipeline of five registered stages: input, mix*max_volts product,
//   reciprocal divide by 25600, sign/max/min, desaturate and saturate into the
//   output register; an accepted item is registered through each stage in turn.
// Throughput is one item per cycle while not stalled; each stage holds one item.
// When the receiver stalls, the output register holds its item and earlier
//   stages keep filling until each holds one item; in_if.ready then drops.
// Reset (synchronous, rst_n low) empties the pipeline, clears the take-off
//   flag and loads max_volts = 9.0 V, min_volts = 0.
`timescale 1ns / 1ps
`default_nettype none

module quad_motor_mixer_with_desaturation_unit
  import qmix_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  qmix_in_if.sink                 in_if,
  qmix_out_if.source              out_if,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [VOLT_W-1:0]  cfg_data
);

  // Configuration registers
  logic [VOLT_W-1:0] max_volts_r;
  logic [VOLT_W-1:0] min_volts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_volts_r <= MAX_VOLTS_RST;
      min_volts_r <= MIN_VOLTS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MAX_VOLTS: max_volts_r <= cfg_data;
        REG_MIN_VOLTS: min_volts_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage ready (a stage loads when empty or draining)
  logic va_r, vb_r, vc_r, vd_r, vo_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  assign rdy_o = !vo_r || out_if.ready;
  assign rdy_d = !vd_r || rdy_o;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_if.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_if.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_o) vo_r <= vd_r;
    end
  end

  // Stage A: input register
  logic signed [CMD_W-1:0] roll_r, pitch_r, yaw_r, thrust_r;

  always_ff @(posedge clk) begin
    if (rdy_a && in_if.valid) begin
      roll_r   <= in_if.roll_cmd;
      pitch_r  <= in_if.pitch_cmd;
      yaw_r    <= in_if.yaw_cmd;
      thrust_r <= in_if.thrust_cmd;
    end
  end

  // Stage B: X-frame mix, times max_volts
  logic signed [MIX_W-1:0]  rx, px, yx, tx;
  logic signed [MIX_W-1:0]  mix [MOTORS];
  logic signed [CMD_W:0]    mv_s;
  logic signed [PROD_W-1:0] prod_nxt [MOTORS];
  logic signed [PROD_W-1:0] prod_r   [MOTORS];

  always_comb begin
    rx = MIX_W'(roll_r);
    px = MIX_W'(pitch_r);
    yx = MIX_W'(yaw_r);
    tx = MIX_W'(thrust_r);
    mix[0] =  rx - px + yx + tx;
    mix[1] = -rx - px - yx + tx;
    mix[2] = -rx + px + yx + tx;
    mix[3] =  rx + px - yx + tx;
    mv_s = $signed({2'b00, max_volts_r});
    for (int i = 0; i < MOTORS; i++) begin
      prod_nxt[i] = mix[i] * mv_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage C: |product| / 25600, truncated toward zero
  logic [MAG_W-1:0]           mag      [MOTORS];
  logic [SHR_W-1:0]           shr      [MOTORS];
  logic [SHR_W+RECIP_W-1:0]   rprod    [MOTORS];
  logic [QUO_W-1:0]           quo_nxt  [MOTORS];
  logic [QUO_W-1:0]           quo_r    [MOTORS];
  logic [MOTORS-1:0]          neg_nxt;
  logic [MOTORS-1:0]          neg_r;

  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      neg_nxt[i] = prod_r[i][PROD_W-1];
      mag[i]     = neg_nxt[i] ? MAG_W'(-prod_r[i]) : MAG_W'(prod_r[i]);
      shr[i]     = mag[i][MAG_W-1:PRE_SHIFT];
      rprod[i]   = (SHR_W+RECIP_W)'(shr[i]) * (SHR_W+RECIP_W)'(RECIP_25);
      quo_nxt[i] = rprod[i][RECIP_SH +: QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      quo_r <= quo_nxt;
      neg_r <= neg_nxt;
    end
  end

  // Stage D: signed drives, take-off flag, max (floored at 0) and min
  logic signed [SQ_W-1:0] drv_nxt [MOTORS];
  logic signed [SQ_W-1:0] drv_r   [MOTORS];
  logic signed [SQ_W-1:0] hi_nxt, lo_nxt, hi_r, lo_r;
  logic                   took_off_r, took_off_nxt, took_r;

  always_comb begin
    took_off_nxt = took_off_r;
    for (int i = 0; i < MOTORS; i++) begin
      drv_nxt[i] = neg_r[i] ? -$signed({1'b0, quo_r[i]}) : $signed({1'b0, quo_r[i]});
      if (drv_nxt[i] > 0) took_off_nxt = 1'b1;
    end
    hi_nxt = '0;
    lo_nxt = drv_nxt[0];
    for (int i = 0; i < MOTORS; i++) begin
      if (drv_nxt[i] > hi_nxt) hi_nxt = drv_nxt[i];
      if (drv_nxt[i] < lo_nxt) lo_nxt = drv_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      took_off_r <= 1'b0;
    end else if (rdy_d && vc_r) begin
      took_off_r <= took_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) begin
      drv_r  <= drv_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      took_r <= took_off_nxt;
    end
  end

  // Stage O: shift down by excess, raise to lower bound, saturate
  logic signed [DS_W-1:0]  mv_w, minv_w, hi_w, lo_w, exc, span, bound;
  logic signed [DS_W-1:0]  d_w     [MOTORS];
  logic signed [DRV_W-1:0] mot_nxt [MOTORS];
  logic signed [DRV_W-1:0] mot_r   [MOTORS];
  logic                    air_r;

  always_comb begin
    mv_w   = $signed(DS_W'(max_volts_r));
    minv_w = $signed(DS_W'(min_volts_r));
    exc    = (DS_W'(hi_r) > mv_w) ? DS_W'(hi_r) - mv_w : '0;
    hi_w   = DS_W'(hi_r) - exc;
    lo_w   = DS_W'(lo_r) - exc;
    span   = mv_w - minv_w;
    if (hi_w - lo_w > span) bound = hi_w - span;
    else if (took_r)        bound = minv_w;
    else                    bound = lo_w;
    for (int i = 0; i < MOTORS; i++) begin
      d_w[i] = DS_W'(drv_r[i]) - exc;
      if (d_w[i] < bound)   d_w[i] = bound;
      if (d_w[i] > DRV_MAX) d_w[i] = DRV_MAX;
      if (d_w[i] < DRV_MIN) d_w[i] = DRV_MIN;
      mot_nxt[i] = d_w[i][DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vd_r) begin
      mot_r <= mot_nxt;
      air_r <= took_r;
    end
  end

  assign out_if.valid             = vo_r;
  assign out_if.motor_front_left  = mot_r[0];
  assign out_if.motor_front_right = mot_r[1];
  assign out_if.motor_rear_right  = mot_r[2];
  assign out_if.motor_rear_left   = mot_r[3];
  assign out_if.airborne          = air_r;

endmodule

`default_nettype wire

### design/qmix_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module qmix_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_airborne
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Take-off flag never clears once shown
  a_air_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_airborne |=> !out_valid || out_airborne)
    else $error("airborne flag cleared");

  // An empty output side never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // in_valid observed for completeness of the monitored channel
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$isunknown(out_valid))
    else $error("result valid unknown");

endmodule

bind quad_motor_mixer_with_desaturation_unit qmix_checker u_qmix_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_airborne (out_if.airborne)
);

`default_nettype wire
